@@ src/aph_pkg.sv @@
// ----------------------------------------------------------------------------
// aph_pkg
// Shared types, codes and constants of the angular pair histogram.
// ----------------------------------------------------------------------------
`default_nettype none
package aph_pkg;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] CFG_ANGLE_TOP = 2'd0;
    localparam logic [1:0] CFG_BINS      = 2'd1;

    localparam logic [17:0] ALPHA_RESET  = 18'd205887;
    localparam logic [8:0]  BINS_RESET   = 9'd256;
    localparam logic [17:0] ANGLE_LIMIT  = 18'd205887;
    localparam logic signed [26:0] HALF_PI_Q24 = 27'sd26353589;
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_TOP     = 30;
    localparam int NUM_W        = 27;
    localparam int DEN_W        = 18;
    localparam logic [47:0] BIN_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ANGLE,
        ST_DIV,
        ST_READ,
        ST_WRITE
    } aph_state_t;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_DOT,
        AS_CLAMP,
        AS_SQUARE,
        AS_SQRT,
        AS_INIT,
        AS_ROTATE,
        AS_DONE
    } ang_state_t;

    function automatic logic [23:0] atan_q24(input logic [4:0] i);
        logic [23:0] v;
        case (i)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ src/aph_ram.sv @@
// ----------------------------------------------------------------------------
// aph_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module aph_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ src/aph_angle.sv @@
// ----------------------------------------------------------------------------
// aph_angle
// Separation angle of two unit vectors: dot product, integer square root and
// CORDIC vectoring, run one after another under one state machine.
// ----------------------------------------------------------------------------
`default_nettype none
module aph_angle (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] a_z,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] b_z,
    output logic               done,
    output logic [17:0]        angle
);
    import aph_pkg::*;

    ang_state_t         st_reg, st_next;
    logic [4:0]         cnt_reg;
    logic signed [15:0] va_reg [3];
    logic signed [15:0] vb_reg [3];
    logic signed [33:0] acc_reg;
    logic signed [31:0] c_reg;
    logic [61:0]        rem_reg, root_reg;
    logic signed [35:0] x_reg, y_reg;
    logic signed [26:0] z_reg;

    logic signed [31:0] prod;
    logic signed [31:0] c_clamp;
    logic [61:0]        bitv, trial;
    logic signed [35:0] dx, dy;
    logic [26:0]        z_pos, z_round;

    assign prod  = va_reg[cnt_reg[1:0]] * vb_reg[cnt_reg[1:0]];
    assign bitv  = 62'd1 << {cnt_reg, 1'b0};
    assign trial = root_reg + bitv;
    assign dx    = y_reg >>> cnt_reg;
    assign dy    = x_reg >>> cnt_reg;

    always_comb
    begin
        if (acc_reg > 34'sd1073741824)
        begin
            c_clamp = 32'sd1073741824;
        end
        else if (acc_reg < -34'sd1073741824)
        begin
            c_clamp = -32'sd1073741824;
        end
        else
        begin
            c_clamp = acc_reg[31:0];
        end
    end

    always_comb
    begin
        z_pos   = z_reg[26] ? 27'd0 : z_reg;
        z_round = (z_pos + 27'd128) >> 8;
        angle   = (z_round > 27'(ANGLE_LIMIT)) ? ANGLE_LIMIT : z_round[17:0];
    end

    assign done = (st_reg == AS_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= AS_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            AS_IDLE:   if (start) st_next = AS_DOT;
            AS_DOT:    if (cnt_reg == 5'd2) st_next = AS_CLAMP;
            AS_CLAMP:  st_next = AS_SQUARE;
            AS_SQUARE: st_next = AS_SQRT;
            AS_SQRT:   if (cnt_reg == 5'd0) st_next = AS_INIT;
            AS_INIT:   st_next = AS_ROTATE;
            AS_ROTATE: if (cnt_reg == 5'(CORDIC_STEPS - 1)) st_next = AS_DONE;
            AS_DONE:   st_next = AS_IDLE;
            default:   st_next = AS_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            AS_IDLE:
            begin
                va_reg[0] <= a_x;
                va_reg[1] <= a_y;
                va_reg[2] <= a_z;
                vb_reg[0] <= b_x;
                vb_reg[1] <= b_y;
                vb_reg[2] <= b_z;
                acc_reg   <= '0;
                cnt_reg   <= '0;
            end
            AS_DOT:
            begin
                acc_reg <= acc_reg + 34'(prod);
                cnt_reg <= cnt_reg + 5'd1;
            end
            AS_CLAMP:
            begin
                c_reg <= c_clamp;
            end
            AS_SQUARE:
            begin
                rem_reg  <= 62'((64'sd1 <<< 60) - (c_reg * c_reg));
                root_reg <= '0;
                cnt_reg  <= 5'(SQRT_TOP);
            end
            AS_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bitv;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            AS_INIT:
            begin
                cnt_reg <= '0;
                if (c_reg < 0)
                begin
                    x_reg <= 36'(root_reg[30:0]);
                    y_reg <= -36'(c_reg);
                    z_reg <= HALF_PI_Q24;
                end
                else
                begin
                    x_reg <= 36'(c_reg);
                    y_reg <= 36'(root_reg[30:0]);
                    z_reg <= '0;
                end
            end
            AS_ROTATE:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + 27'(atan_q24(cnt_reg));
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - 27'(atan_q24(cnt_reg));
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

@@ src/aph_div.sv @@
// ----------------------------------------------------------------------------
// aph_div
// Restoring divider, one quotient bit per cycle, for the bin number.
// ----------------------------------------------------------------------------
`default_nettype none
module aph_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [aph_pkg::NUM_W-1:0] num,
    input  logic [aph_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [aph_pkg::NUM_W-1:0] quo
);
    import aph_pkg::*;

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg, rem_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quo   = num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == 5'd0))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            cnt_reg <= 5'(NUM_W - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], fits};
            cnt_reg <= cnt_reg - 5'd1;
        end
    end
endmodule
`default_nettype wire

@@ src/angular_pair_histogram.sv @@
// ----------------------------------------------------------------------------
// angular_pair_histogram
// Weighted histogram of angular separations of point pairs.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser[0] selects accumulate (0) or
// read (1). An accumulate request computes the pair angle, bins it and adds
// the weight product, doubled unless self_pair is set, to the bin in a
// histogram memory with a read-modify-write; a read request returns one bin.
// Every request gives exactly one result on m_axis. The cfg channel writes the
// angle limit (index 0) and bins_in_use (index 1) and is always ready.
// One request is worked at a time. An accumulate request runs the dot product,
// the clamp and square, the square-root unit, the CORDIC load and loop, the
// hand-over of the angle, the bin divider and the memory read and write, in
// that order. A pair outside the range skips the divider and the memory, and
// a read request only reads the memory. The next request is taken at the
// earliest once the result has been registered and the block is idle.
// After reset the block sweeps the memory to zero, one bin per cycle, with
// s_axis_tready low. The result sits in an output register; the next
// request is accepted and worked while it waits, and only the final write
// waits until the receiver has taken the previous result.
// ----------------------------------------------------------------------------
`default_nettype none
module angular_pair_histogram #(
    parameter int NUM_BINS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, weight_a, weight_b, read_index
    input  logic [135:0] s_axis_tdata,
    // command, self_pair
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bin_index, pair_angle, bin_value, zero fill
    output logic [79:0]  m_axis_tdata,
    // in_range
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [17:0]  cfg_data
);
    import aph_pkg::*;

    localparam int BINW = $clog2(NUM_BINS);

    aph_state_t      st_reg, st_next;
    logic [BINW:0]   clr_reg;
    logic [17:0]     alpha_reg;
    logic [8:0]      bins_reg;
    logic            cmd_reg;
    logic            oor_reg;
    logic            rd_ok_reg;
    logic [BINW-1:0] addr_reg;
    logic [7:0]      idx_reg;
    logic [17:0]     angle_reg;
    logic [32:0]     inc_reg;
    logic            out_valid_reg;
    logic [79:0]     out_data_reg;
    logic            out_user_reg;

    logic            accept, ang_done, div_done, div_start, finish;
    logic [17:0]     ang;
    logic [NUM_W-1:0] quo;
    logic [8:0]      bins_eff;
    logic [BINW-1:0] bin_sel;
    logic            ram_we;
    logic [BINW-1:0] ram_waddr;
    logic [47:0]     ram_wdata, ram_rdata;
    logic [48:0]     sum;
    logic [47:0]     sum_sat;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (st_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_comb
    begin
        if (bins_reg == 9'd0)
        begin
            bins_eff = 9'd1;
        end
        else if (int'(bins_reg) > NUM_BINS)
        begin
            bins_eff = 9'(NUM_BINS);
        end
        else
        begin
            bins_eff = bins_reg;
        end
    end

    assign bin_sel = (quo >= NUM_W'(bins_eff)) ? BINW'(bins_eff - 9'd1) : quo[BINW-1:0];
    assign sum     = {1'b0, ram_rdata} + 49'(inc_reg);
    assign sum_sat = sum[48] ? BIN_MAX : sum[47:0];

    aph_angle u_angle (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && (s_axis_tuser[0] == CMD_ACCUM)),
        .a_x   (s_axis_tdata[15:0]),
        .a_y   (s_axis_tdata[31:16]),
        .a_z   (s_axis_tdata[47:32]),
        .b_x   (s_axis_tdata[63:48]),
        .b_y   (s_axis_tdata[79:64]),
        .b_z   (s_axis_tdata[95:80]),
        .done  (ang_done),
        .angle (ang)
    );

    aph_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (NUM_W'(ang * bins_eff)),
        .den   (alpha_reg),
        .done  (div_done),
        .quo   (quo)
    );

    aph_ram #(
        .WIDTH (48),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_CLEAR;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        div_start = 1'b0;
        finish    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = sum_sat;
        case (st_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg[BINW-1:0];
                ram_wdata = '0;
                if (clr_reg == (BINW+1)'(NUM_BINS - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    st_next = (s_axis_tuser[0] == CMD_READ) ? ST_READ : ST_ANGLE;
                end
            end
            ST_ANGLE:
            begin
                if (ang_done)
                begin
                    if (ang >= alpha_reg)
                    begin
                        st_next = ST_WRITE;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        st_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    st_next = ST_READ;
                end
            end
            ST_READ:
            begin
                st_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    finish  = 1'b1;
                    ram_we  = (cmd_reg == CMD_ACCUM) && !oor_reg;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            alpha_reg     <= ALPHA_RESET;
            bins_reg      <= BINS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid && (cfg_index == CFG_ANGLE_TOP))
            begin
                alpha_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_BINS))
            begin
                bins_reg <= cfg_data[8:0];
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_axis_tuser[0];
            oor_reg   <= 1'b0;
            idx_reg   <= s_axis_tdata[135:128];
            rd_ok_reg <= int'(s_axis_tdata[135:128]) < NUM_BINS;
            addr_reg  <= BINW'(s_axis_tdata[135:128]);
            angle_reg <= '0;
            if (s_axis_tuser[1])
            begin
                inc_reg <= 33'(s_axis_tdata[111:96] * s_axis_tdata[127:112]);
            end
            else
            begin
                inc_reg <= {32'(s_axis_tdata[111:96] * s_axis_tdata[127:112]), 1'b0};
            end
        end
        if ((st_reg == ST_ANGLE) && ang_done)
        begin
            angle_reg <= ang;
            oor_reg   <= (ang >= alpha_reg);
        end
        if ((st_reg == ST_DIV) && div_done)
        begin
            addr_reg <= bin_sel;
        end
        if (finish)
        begin
            if (cmd_reg == CMD_READ)
            begin
                out_data_reg <= {6'd0, (rd_ok_reg ? ram_rdata : 48'd0), 18'd0, idx_reg};
                out_user_reg <= 1'b0;
            end
            else if (oor_reg)
            begin
                out_data_reg <= {6'd0, 48'd0, angle_reg, 8'd0};
                out_user_reg <= 1'b0;
            end
            else
            begin
                out_data_reg <= {6'd0, sum_sat, angle_reg, 8'(addr_reg)};
                out_user_reg <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ src/aph_checker.sv @@
// ----------------------------------------------------------------------------
// aph_checker
// Port-level checks of the angular pair histogram, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module aph_port_checks (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [79:0]  m_axis_tdata,
    input logic         m_axis_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    a_angle_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[25:8] <= 18'd205887)
        else $error("pair angle above limit");

    a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser && (m_axis_tdata[25:8] != 18'd0)
        |-> (m_axis_tdata[73:26] == 48'd0) && (m_axis_tdata[7:0] == 8'd0))
        else $error("dropped pair reports a bin");
endmodule

bind angular_pair_histogram aph_port_checks u_aph_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
